// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked at the following edge, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/swmd5_pkg.sv
// Shared types, constants and MD5 round tables for the sliding window MD5 search.
// No dependencies.
`timescale 1ns / 1ps

package swmd5_pkg;

   localparam int MAX_WINDOW_DEFAULT = 55;
   localparam int ROUNDS             = 64;

   localparam logic [5:0] WINDOW_LENGTH_RESET = 6'd19;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_WINDOW_LENGTH    = 2'd0;
   localparam logic [1:0] CSR_TARGET_HASH_HIGH = 2'd1;
   localparam logic [1:0] CSR_TARGET_HASH_LOW  = 2'd2;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [31:0] MD5_K [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int MD5_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

   typedef logic [15:0][31:0] swmd5_block_type;

   typedef struct packed {
      logic        valid;
      logic        checked;
      logic [31:0] start;
   } swmd5_meta_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } swmd5_state_type;

   function automatic int md5_word_index(input int r);
      int g;
      if (r < 16)      g = r;
      else if (r < 32) g = (5 * r + 1) % 16;
      else if (r < 48) g = (3 * r + 5) % 16;
      else             g = (7 * r) % 16;
      return g;
   endfunction

   function automatic int md5_shift(input int r);
      return MD5_ROT[((r / 16) * 4) + (r % 4)];
   endfunction

   function automatic logic [31:0] byte_swap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

// File: rtl/swmd5_round_cell.sv
// One MD5 round as a registered cell of the round chain.
// Depends on swmd5_pkg.
`timescale 1ns / 1ps

module swmd5_round_cell #(
   parameter int ROUND = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  swmd5_pkg::swmd5_state_type state_in,
   input  swmd5_pkg::swmd5_block_type block_in,
   input  swmd5_pkg::swmd5_meta_type  meta_in,
   output swmd5_pkg::swmd5_state_type state_out,
   output swmd5_pkg::swmd5_block_type block_out,
   output swmd5_pkg::swmd5_meta_type  meta_out
);
   import swmd5_pkg::*;

   localparam int          WIDX  = md5_word_index(ROUND);
   localparam int          SHIFT = md5_shift(ROUND);
   localparam logic [31:0] KCON  = MD5_K[ROUND];

   swmd5_state_type state_ff, state_in_w;
   swmd5_block_type block_ff;
   swmd5_meta_type  meta_ff;
   logic [31:0]     f_w, sum_w, rot_w;

   always_comb begin
      if (ROUND < 16)      f_w = (state_in.b & state_in.c) | (~state_in.b & state_in.d);
      else if (ROUND < 32) f_w = (state_in.d & state_in.b) | (~state_in.d & state_in.c);
      else if (ROUND < 48) f_w = state_in.b ^ state_in.c ^ state_in.d;
      else                 f_w = state_in.c ^ (state_in.b | ~state_in.d);
      sum_w = state_in.a + f_w + KCON + block_in[WIDX];
      rot_w = (sum_w << SHIFT) | (sum_w >> (32 - SHIFT));
      state_in_w.a = state_in.d;
      state_in_w.d = state_in.c;
      state_in_w.c = state_in.b;
      state_in_w.b = state_in.b + rot_w;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff      <= state_in_w;
         block_ff      <= block_in;
         meta_ff.checked <= meta_in.checked;
         meta_ff.start <= meta_in.start;
      end
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (advance) begin
         meta_ff.valid <= meta_in.valid;
      end
   end

   assign state_out = state_ff;
   assign block_out = block_ff;
   assign meta_out  = meta_ff;

endmodule

// File: rtl/swmd5_window.sv
// Byte window shift line, fill and position counters, and MD5 block padding.
// Depends on swmd5_pkg.
`timescale 1ns / 1ps

module swmd5_window #(
   parameter int MAX_WINDOW = swmd5_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     accept,
   input  logic [7:0]               text_byte,
   input  logic                     stream_start,
   input  logic [5:0]               window_length,
   output swmd5_pkg::swmd5_block_type block_out,
   output swmd5_pkg::swmd5_meta_type  meta_out
);
   import swmd5_pkg::*;

   localparam int         IW   = $clog2(MAX_WINDOW);
   localparam int         FW   = $clog2(MAX_WINDOW + 1);
   localparam logic [5:0] MAXN = 6'(MAX_WINDOW);

   logic [7:0]      win_ff [MAX_WINDOW];
   logic [7:0]      win_in [MAX_WINDOW];
   logic [FW-1:0]   fill_ff, fill_in;
   logic [31:0]     pos_ff, pos_in, pos_cur;
   logic [5:0]      n_w;
   logic [7:0]      blk_w [64];
   swmd5_block_type block_ff, block_in;
   swmd5_meta_type  meta_ff, meta_in;

   always_comb begin
      int idx;
      idx = 0;
      if (window_length < 6'd2)      n_w = 6'd2;
      else if (window_length > MAXN) n_w = MAXN;
      else                           n_w = window_length;

      for (int i = 0; i < MAX_WINDOW - 1; i++) win_in[i] = win_ff[i + 1];
      win_in[MAX_WINDOW - 1] = text_byte;

      if (stream_start)                      fill_in = FW'(1);
      else if (fill_ff < FW'(MAX_WINDOW))    fill_in = fill_ff + FW'(1);
      else                                   fill_in = fill_ff;
      pos_cur = stream_start ? 32'd0 : pos_ff;
      pos_in  = pos_cur + 32'd1;

      for (int j = 0; j < 64; j++) begin
         idx = MAX_WINDOW - int'(n_w) + j;
         if (j < int'(n_w))       blk_w[j] = win_in[IW'(idx)];
         else if (j == int'(n_w)) blk_w[j] = 8'h80;
         else if (j == 56)        blk_w[j] = {n_w[4:0], 3'b000};
         else if (j == 57)        blk_w[j] = {7'b0000000, n_w[5]};
         else                     blk_w[j] = 8'h00;
      end
      for (int w = 0; w < 16; w++)
         block_in[w] = {blk_w[4*w+3], blk_w[4*w+2], blk_w[4*w+1], blk_w[4*w]};

      meta_in.valid   = accept;
      meta_in.checked = (32'(fill_in) >= 32'(n_w));
      meta_in.start   = pos_cur - 32'(n_w - 6'd1);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
      if (advance) begin
         block_ff        <= block_in;
         meta_ff.checked <= meta_in.checked;
         meta_ff.start   <= meta_in.start;
      end
      if (reset) begin
         fill_ff       <= '0;
         pos_ff        <= '0;
         meta_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
            pos_ff  <= pos_in;
         end
         if (advance) meta_ff.valid <= meta_in.valid;
      end
   end

   assign block_out = block_ff;
   assign meta_out  = meta_ff;

endmodule

// File: rtl/sliding_window_md5_search_core.sv
// Top level of the sliding window MD5 search: window stage, 64 round cells, output skid.
// Depends on swmd5_pkg, swmd5_window and swmd5_round_cell.
//
//  channel | direction | ports                     | contents
//  req     | in        | tvalid tready tdata tuser | text byte, stream start flag
//  rsp     | out       | tvalid tready tdata tuser | window start, checked / matched flags
//  csr     | in        | valid ready index data    | register writes, always ready
//
// One byte is taken per cycle while the skid register is empty; a result passes in turn
// through the window stage (loaded on the transfer edge), the 64 round cells and the
// output register.
// Reset clears the window fill, the position and all valid flags; registers go to defaults.
// A stalled result sits in the output register; one more result lands in a skid
// register, and input is held while the skid is full.
`timescale 1ns / 1ps

module sliding_window_md5_search_core #(
   parameter int MAX_WINDOW = swmd5_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] stream_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] window_start
   output logic [1:0]  rsp_tuser,   // [0] hash_checked, [1] hash_matched
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import swmd5_pkg::*;

   logic [5:0]      wlen_ff;
   logic [63:0]     thi_ff, tlo_ff;
   logic            advance, accept;
   swmd5_state_type st   [ROUNDS + 1];
   swmd5_block_type blk  [ROUNDS + 1];
   swmd5_meta_type  meta [ROUNDS + 1];
   logic [31:0]     fa_w, fb_w, fc_w, fd_w;
   logic            match_w, fin_v;
   logic [33:0]     fin_w;
   logic            out_v_ff, skid_v_ff;
   logic [33:0]     out_ff, skid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WINDOW_LENGTH_RESET;
         thi_ff  <= '0;
         tlo_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:    wlen_ff <= csr_data[5:0];
            CSR_TARGET_HASH_HIGH: thi_ff  <= csr_data;
            CSR_TARGET_HASH_LOW:  tlo_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign advance    = !skid_v_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   swmd5_window #(.MAX_WINDOW(MAX_WINDOW)) u_window (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .accept        (accept),
      .text_byte     (req_tdata),
      .stream_start  (req_tuser),
      .window_length (wlen_ff),
      .block_out     (blk[0]),
      .meta_out      (meta[0])
   );

   assign st[0] = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      swmd5_round_cell #(.ROUND(r)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .state_in  (st[r]),
         .block_in  (blk[r]),
         .meta_in   (meta[r]),
         .state_out (st[r + 1]),
         .block_out (blk[r + 1]),
         .meta_out  (meta[r + 1])
      );
   end

   always_comb begin
      fa_w    = st[ROUNDS].a + IV_A;
      fb_w    = st[ROUNDS].b + IV_B;
      fc_w    = st[ROUNDS].c + IV_C;
      fd_w    = st[ROUNDS].d + IV_D;
      match_w = ({byte_swap(fa_w), byte_swap(fb_w)} == thi_ff) &&
                ({byte_swap(fc_w), byte_swap(fd_w)} == tlo_ff);
      fin_v   = meta[ROUNDS].valid && advance;
      fin_w   = meta[ROUNDS].checked ?
                {match_w, 1'b1, meta[ROUNDS].start} : 34'd0;
   end

   // Output register with a one-deep skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_ff   <= fin_w;
            out_v_ff <= fin_v;
         end
      end else if (fin_v) begin
         skid_ff   <= fin_w;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff[31:0];
   assign rsp_tuser  = {out_ff[33], out_ff[32]};

endmodule

// File: rtl/swmd5_checker.sv
// Port-level checks for the sliding window MD5 search core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swmd5_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")
   `ASSERT_IMPLY(a_match_checked, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0], "match without a hash")
   `ASSERT_IMPLY(a_unchecked_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 32'd0 && !rsp_tuser[1], "unchecked result not zero")
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset), !rsp_tvalid, "result straight after reset")
   `ASSERT_NEXT(a_ready_after_drain, clock, reset, !rsp_tvalid, req_tready, "input held with output empty")

endmodule

bind sliding_window_md5_search_core swmd5_checker u_swmd5_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
